// ===== hw/rtl/aocad_pkg.sv =====
// Shared types and constants for the oriented-box anchor decoder.
// Holds the item structs, field widths and register indexes; no dependencies.
`default_nettype none

package aocad_pkg;

   // Field and register widths
   localparam int VALUE_BITS     = 32;
   localparam int FRAC_BITS      = 16;
   localparam int NC_BITS        = 8;
   localparam int FACTOR_BITS    = 24;
   localparam int SIZE_BITS      = 14;
   localparam int LIMIT_BITS     = 16;
   localparam int KEPT_BITS      = 17;
   localparam int CHAN_BITS      = 9;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;

   // Number of box channels (cx, cy, w, h) at the start of each anchor
   localparam int BOX_CHANNELS = 4;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_NUM_CLASSES     = 3'd0,
      CSR_SCORE_THRESHOLD = 3'd1,
      CSR_X_FACTOR        = 3'd2,
      CSR_Y_FACTOR        = 3'd3,
      CSR_IMAGE_WIDTH     = 3'd4,
      CSR_IMAGE_HEIGHT    = 3'd5,
      CSR_BOX_LIMIT       = 3'd6
   } csr_index_type;

   // One input item: a single detector channel value
   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         first_of_frame;
   } req_type;

   // One result item: a decoded box
   typedef struct packed {
      logic signed [VALUE_BITS-1:0] left;
      logic signed [VALUE_BITS-1:0] top;
      logic signed [VALUE_BITS-1:0] right;
      logic signed [VALUE_BITS-1:0] bottom;
      logic signed [VALUE_BITS-1:0] center_x;
      logic signed [VALUE_BITS-1:0] center_y;
      logic signed [VALUE_BITS-1:0] box_width;
      logic signed [VALUE_BITS-1:0] box_height;
      logic signed [VALUE_BITS-1:0] rotation;
      logic signed [VALUE_BITS-1:0] confidence;
      logic [NC_BITS-1:0]           class_index;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/anchor_obb_class_argmax_decode_top.sv =====
// Oriented-box anchor decoder: per-anchor class argmax, threshold, scaling and clamping.
// Depends on aocad_pkg for the item structs, widths and register indexes.
//
// The block takes one channel value per clock cycle in anchor order (cx, cy, w, h,
// the class scores, then the angle) whenever req_ready is high.
// Box and class values only update running state in the cycle they are accepted;
// an angle whose best score passes the threshold launches a box into a four-register
// pipeline (operand, product, rounded/saturated, result) and leaves from the result
// register; back-pressure on the result can hold it in place. The six scaling
// multipliers (34 x 25 bits) each have a register after them. req_ready only falls
// when all four pipeline registers hold boxes and the result is not being taken.
// Configuration writes are taken at any time but must only be made while idle.
`default_nettype none

module anchor_obb_class_argmax_decode_top
   import aocad_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   // Input channel
   input  wire                      req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   // Result channel
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output rsp_type                  rsp_data,
   // Configuration write port
   input  wire                      csr_write,
   input  wire [CSR_INDEX_BITS-1:0] csr_index,
   input  wire [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int VB  = VALUE_BITS;
   // Operand width: 2*cx - w needs two bits over the value width
   localparam int AW  = VB + 2;
   // Product width: signed operand times the factor as a positive signed value
   localparam int PW  = AW + FACTOR_BITS + 1;
   localparam int NUM_PRODUCTS = 6;

   localparam logic signed [PW-1:0] SAT_HI = {{(PW-VB+1){1'b0}}, {(VB-1){1'b1}}};
   localparam logic signed [PW-1:0] SAT_LO = {{(PW-VB+1){1'b1}}, {(VB-1){1'b0}}};

   typedef struct packed {
      logic signed [VB-1:0] rotation;
      logic signed [VB-1:0] confidence;
      logic [NC_BITS-1:0]   class_index;
   } carry_type;

   // Saturate a wide signed value to the value width
   function automatic logic signed [VB-1:0] sat_v(input logic signed [PW-1:0] x);
      logic signed [VB-1:0] r;
      if (x > SAT_HI) begin
         r = SAT_HI[VB-1:0];
      end else if (x < SAT_LO) begin
         r = SAT_LO[VB-1:0];
      end else begin
         r = x[VB-1:0];
      end
      return r;
   endfunction

   // Configuration registers
   logic [NC_BITS-1:0]          num_classes_ff;
   logic signed [VB-1:0]        score_threshold_ff;
   logic [FACTOR_BITS-1:0]      x_factor_ff;
   logic [FACTOR_BITS-1:0]      y_factor_ff;
   logic [SIZE_BITS-1:0]        image_width_ff;
   logic [SIZE_BITS-1:0]        image_height_ff;
   logic [LIMIT_BITS-1:0]       box_limit_ff;

   // Per-anchor and per-frame state
   logic [CHAN_BITS-1:0]        channel_index_ff, channel_index_in;
   logic signed [VB-1:0]        raw_box_ff [BOX_CHANNELS];
   logic signed [VB-1:0]        best_score_ff, best_score_in;
   logic [NC_BITS-1:0]          best_class_ff, best_class_in;
   logic [KEPT_BITS-1:0]        kept_count_ff, kept_count_in;
   logic                        frame_done_ff, frame_done_in;

   // Pipeline registers
   logic                        s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic signed [AW-1:0]        oper_ff [NUM_PRODUCTS];
   carry_type                   s1_carry_ff, s2_carry_ff, s3_carry_ff;
   logic signed [PW-1:0]        prod_ff [NUM_PRODUCTS];
   logic signed [VB-1:0]        scaled_ff [NUM_PRODUCTS];
   rsp_type                     rsp_data_ff, rsp_data_in;

   // Control decode
   logic                        accept;
   logic [CHAN_BITS-1:0]        chan_eff;
   logic [CHAN_BITS-1:0]        angle_pos;
   logic [KEPT_BITS-1:0]        kept_eff;
   logic [KEPT_BITS-1:0]        kept_next;
   logic                        frame_done_eff;
   logic                        is_box, is_class, is_angle, emit;
   logic [NC_BITS-1:0]          class_pos;
   logic                        out_free, s3_free, s2_free, s1_free;
   logic signed [PW-1:0]        rounded [NUM_PRODUCTS];
   logic signed [SIZE_BITS:0]   width_m1, height_m1;
   logic signed [VB-1:0]        bound_x, bound_y, sum_x, sum_y;

   // Pipeline flow: a stage may load when it is empty or when it drains onwards
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      s3_free   = !s3_valid_ff || out_free;
      s2_free   = !s2_valid_ff || s3_free;
      s1_free   = !s1_valid_ff || s2_free;
      req_ready = s1_free;
      accept    = req_valid && s1_free;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_classes_ff     <= NC_BITS'(15);
         score_threshold_ff <= VB'(16384);
         x_factor_ff        <= FACTOR_BITS'(65536);
         y_factor_ff        <= FACTOR_BITS'(65536);
         image_width_ff     <= SIZE_BITS'(640);
         image_height_ff    <= SIZE_BITS'(640);
         box_limit_ff       <= LIMIT_BITS'(30000);
      end else if (csr_write) begin
         case (csr_index)
            CSR_NUM_CLASSES:     num_classes_ff     <= csr_data[NC_BITS-1:0];
            CSR_SCORE_THRESHOLD: score_threshold_ff <= $signed(csr_data[VB-1:0]);
            CSR_X_FACTOR:        x_factor_ff        <= csr_data[FACTOR_BITS-1:0];
            CSR_Y_FACTOR:        y_factor_ff        <= csr_data[FACTOR_BITS-1:0];
            CSR_IMAGE_WIDTH:     image_width_ff     <= csr_data[SIZE_BITS-1:0];
            CSR_IMAGE_HEIGHT:    image_height_ff    <= csr_data[SIZE_BITS-1:0];
            CSR_BOX_LIMIT:       box_limit_ff       <= csr_data[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Channel decode and running argmax for the accepted item
   always_comb begin
      chan_eff       = req_data.first_of_frame ? '0 : channel_index_ff;
      kept_eff       = req_data.first_of_frame ? '0 : kept_count_ff;
      frame_done_eff = req_data.first_of_frame ? 1'b0 : frame_done_ff;
      // A class count of zero behaves as one class
      angle_pos      = CHAN_BITS'(BOX_CHANNELS)
                     + ((num_classes_ff == '0) ? CHAN_BITS'(1) : CHAN_BITS'(num_classes_ff));
      is_box         = chan_eff < CHAN_BITS'(BOX_CHANNELS);
      is_class       = !is_box && (chan_eff < angle_pos);
      is_angle       = !is_box && !is_class;
      class_pos      = NC_BITS'(chan_eff - CHAN_BITS'(BOX_CHANNELS));
      emit           = is_angle && !frame_done_eff && (best_score_ff >= score_threshold_ff);
      kept_next      = kept_eff + KEPT_BITS'(1);

      channel_index_in = is_angle ? '0 : chan_eff + CHAN_BITS'(1);
      best_score_in    = best_score_ff;
      best_class_in    = best_class_ff;
      if (is_class && ((class_pos == '0) || (req_data.value > best_score_ff))) begin
         best_score_in = req_data.value;
         best_class_in = class_pos;
      end
      kept_count_in = emit ? kept_next : kept_eff;
      frame_done_in = frame_done_eff
                    || (emit && (kept_next > KEPT_BITS'(box_limit_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_index_ff <= '0;
         best_score_ff    <= '0;
         best_class_ff    <= '0;
         kept_count_ff    <= '0;
         frame_done_ff    <= 1'b0;
         for (int i = 0; i < BOX_CHANNELS; i++) begin
            raw_box_ff[i] <= '0;
         end
      end else if (accept) begin
         channel_index_ff <= channel_index_in;
         best_score_ff    <= best_score_in;
         best_class_ff    <= best_class_in;
         kept_count_ff    <= kept_count_in;
         frame_done_ff    <= frame_done_in;
         if (is_box) begin
            raw_box_ff[chan_eff[1:0]] <= req_data.value;
         end
      end
   end

   // Valid bits of the four pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= accept && emit;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // Operand register: corner offsets, size and centre at operand width
   always_ff @(posedge clock) begin
      if (s1_free) begin
         oper_ff[0] <= (AW'(raw_box_ff[0]) <<< 1) - AW'(raw_box_ff[2]);
         oper_ff[1] <= (AW'(raw_box_ff[1]) <<< 1) - AW'(raw_box_ff[3]);
         oper_ff[2] <= AW'(raw_box_ff[2]);
         oper_ff[3] <= AW'(raw_box_ff[3]);
         oper_ff[4] <= AW'(raw_box_ff[0]);
         oper_ff[5] <= AW'(raw_box_ff[1]);
         s1_carry_ff.rotation    <= req_data.value;
         s1_carry_ff.confidence  <= best_score_ff;
         s1_carry_ff.class_index <= best_class_ff;
      end
   end

   // Product register: even products use the horizontal factor, odd the vertical
   always_ff @(posedge clock) begin
      if (s2_free) begin
         for (int i = 0; i < NUM_PRODUCTS; i++) begin
            prod_ff[i] <= PW'(oper_ff[i]) * PW'($signed({1'b0,
                             ((i % 2) == 0) ? x_factor_ff : y_factor_ff}));
         end
         s2_carry_ff <= s1_carry_ff;
      end
   end

   // Round to nearest with ties upward; the corner terms carry an extra halving
   always_comb begin
      for (int i = 0; i < NUM_PRODUCTS; i++) begin
         if (i < 2) begin
            rounded[i] = (prod_ff[i] + (PW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
         end else begin
            rounded[i] = (prod_ff[i] + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_free) begin
         for (int i = 0; i < NUM_PRODUCTS; i++) begin
            scaled_ff[i] <= sat_v(rounded[i]);
         end
         s3_carry_ff <= s2_carry_ff;
      end
   end

   // Far edges and clamping into the image
   always_comb begin
      width_m1  = $signed({1'b0, image_width_ff}) - (SIZE_BITS + 1)'(1);
      height_m1 = $signed({1'b0, image_height_ff}) - (SIZE_BITS + 1)'(1);
      bound_x   = sat_v(PW'(width_m1) <<< FRAC_BITS);
      bound_y   = sat_v(PW'(height_m1) <<< FRAC_BITS);
      sum_x     = sat_v(PW'(scaled_ff[0]) + PW'(scaled_ff[2]));
      sum_y     = sat_v(PW'(scaled_ff[1]) + PW'(scaled_ff[3]));

      rsp_data_in.left        = (scaled_ff[0] < 0) ? '0 : scaled_ff[0];
      rsp_data_in.top         = (scaled_ff[1] < 0) ? '0 : scaled_ff[1];
      rsp_data_in.right       = (sum_x > bound_x) ? bound_x : sum_x;
      rsp_data_in.bottom      = (sum_y > bound_y) ? bound_y : sum_y;
      rsp_data_in.center_x    = scaled_ff[4];
      rsp_data_in.center_y    = scaled_ff[5];
      rsp_data_in.box_width   = scaled_ff[2];
      rsp_data_in.box_height  = scaled_ff[3];
      rsp_data_in.rotation    = s3_carry_ff.rotation;
      rsp_data_in.confidence  = s3_carry_ff.confidence;
      rsp_data_in.class_index = s3_carry_ff.class_index;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Input stalls only when every pipeline register holds a box and the result waits
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled with room in the pipeline");

   // A result appears only after a box has reached the last pipeline register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s3_valid_ff))
      else $error("result raised without a box in the last stage");

   // Once the frame is done no box is launched until a new frame starts
   assert property (@(posedge clock) disable iff (reset)
      (accept && frame_done_ff && !req_data.first_of_frame) |=> !s1_valid_ff)
      else $error("box launched after the frame limit");

   // The position within an anchor never passes the angle of the largest class count
   assert property (@(posedge clock) disable iff (reset)
      channel_index_ff <= CHAN_BITS'(BOX_CHANNELS + 255))
      else $error("channel position out of range");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_anchor_obb_class_argmax_decode_top.sv =====
// Self-checking bench for the oriented-box anchor decoder: streams anchors, predicts boxes.
// Depends on aocad_pkg and anchor_obb_class_argmax_decode_top; no files or arguments.
`timescale 1ns / 1ps

module tb_anchor_obb_class_argmax_decode_top;
   import aocad_pkg::*;

   localparam int     QUIET_LIMIT   = 1000;
   localparam int     SETTLE_CYCLES = 8;
   localparam longint VALUE_MAX     = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
   localparam longint VALUE_MIN     = -VALUE_MAX - 1;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write = 1'b0;
   csr_index_type             csr_index = CSR_NUM_CLASSES;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   // Register copies as the decoder sees them
   logic [NC_BITS-1:0]            cfg_num_classes;
   logic signed [VALUE_BITS-1:0]  cfg_threshold;
   logic [FACTOR_BITS-1:0]        cfg_x_factor;
   logic [FACTOR_BITS-1:0]        cfg_y_factor;
   logic [SIZE_BITS-1:0]          cfg_image_width;
   logic [SIZE_BITS-1:0]          cfg_image_height;
   logic [LIMIT_BITS-1:0]         cfg_box_limit;

   // Running anchor state of the predictor
   int                            chan_pos;
   logic signed [VALUE_BITS-1:0]  box_raw [BOX_CHANNELS];
   logic signed [VALUE_BITS-1:0]  top_score;
   logic [NC_BITS-1:0]            top_class;
   logic [KEPT_BITS-1:0]          boxes_kept;
   bit                            frame_closed;

   rsp_type expected_boxes [$];
   int      mismatches  = 0;
   int      sent_items  = 0;
   int      quiet_cycles = 0;
   int      stall_left  = 0;
   bit      tx_idle_on  = 1'b1;
   bit      rx_idle_on  = 1'b1;

   // What the stimulus generator assumes about the current settings
   int                            gen_classes   = 15;
   logic signed [VALUE_BITS-1:0]  gen_threshold = 16384;

   anchor_obb_class_argmax_decode_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Saturation to the signed value width.
   function automatic longint clip_value(input longint x);
      if (x > VALUE_MAX) return VALUE_MAX;
      if (x < VALUE_MIN) return VALUE_MIN;
      return x;
   endfunction

   // Product scaled down by 2^shift, rounded half up, then saturated.
   function automatic longint scale_round(input longint a, input longint factor, input int shift);
      longint p;
      p = a * factor + (longint'(1) <<< (shift - 1));
      return clip_value(p >>> shift);
   endfunction

   function automatic void reset_model();
      cfg_num_classes  = 8'd15;
      cfg_threshold    = 32'sd16384;
      cfg_x_factor     = 24'd65536;
      cfg_y_factor     = 24'd65536;
      cfg_image_width  = 14'd640;
      cfg_image_height = 14'd640;
      cfg_box_limit    = 16'd30000;
      chan_pos         = 0;
      foreach (box_raw[i]) box_raw[i] = '0;
      top_score        = '0;
      top_class        = '0;
      boxes_kept       = '0;
      frame_closed     = 1'b0;
   endfunction

   // Takes one channel value into the anchor state; returns 1 when a box is emitted.
   function automatic bit predict_box(input logic signed [VALUE_BITS-1:0] v,
                                      input logic first, output rsp_type box);
      int     classes;
      longint x1, y1, ws, hs, cxs, cys, x_bound, y_bound, right_edge, bottom_edge;
      box = '0;
      classes = (cfg_num_classes == 0) ? 1 : int'(cfg_num_classes);
      if (first) begin
         chan_pos     = 0;
         boxes_kept   = '0;
         frame_closed = 1'b0;
      end
      if (chan_pos < BOX_CHANNELS) begin
         box_raw[chan_pos] = v;
         chan_pos++;
         return 1'b0;
      end
      // Class scores: the first strictly larger score takes over.
      if (chan_pos < BOX_CHANNELS + classes) begin
         if (chan_pos == BOX_CHANNELS || v > top_score) begin
            top_score = v;
            top_class = NC_BITS'(chan_pos - BOX_CHANNELS);
         end
         chan_pos++;
         return 1'b0;
      end
      // Anything further along is the angle, which closes the anchor.
      chan_pos = 0;
      if (frame_closed || top_score < cfg_threshold) return 1'b0;

      x1  = scale_round(2 * longint'(box_raw[0]) - longint'(box_raw[2]), cfg_x_factor,
                        FRAC_BITS + 1);
      y1  = scale_round(2 * longint'(box_raw[1]) - longint'(box_raw[3]), cfg_y_factor,
                        FRAC_BITS + 1);
      ws  = scale_round(longint'(box_raw[2]), cfg_x_factor, FRAC_BITS);
      hs  = scale_round(longint'(box_raw[3]), cfg_y_factor, FRAC_BITS);
      cxs = scale_round(longint'(box_raw[0]), cfg_x_factor, FRAC_BITS);
      cys = scale_round(longint'(box_raw[1]), cfg_y_factor, FRAC_BITS);
      x_bound = clip_value((longint'(cfg_image_width) - 1) <<< FRAC_BITS);
      y_bound = clip_value((longint'(cfg_image_height) - 1) <<< FRAC_BITS);
      right_edge  = clip_value(x1 + ws);
      bottom_edge = clip_value(y1 + hs);
      if (right_edge > x_bound) right_edge = x_bound;
      if (bottom_edge > y_bound) bottom_edge = y_bound;

      box.left        = (x1 < 0) ? '0 : VALUE_BITS'(x1);
      box.top         = (y1 < 0) ? '0 : VALUE_BITS'(y1);
      box.right       = VALUE_BITS'(right_edge);
      box.bottom      = VALUE_BITS'(bottom_edge);
      box.center_x    = VALUE_BITS'(cxs);
      box.center_y    = VALUE_BITS'(cys);
      box.box_width   = VALUE_BITS'(ws);
      box.box_height  = VALUE_BITS'(hs);
      box.rotation    = v;
      box.confidence  = top_score;
      box.class_index = top_class;

      boxes_kept = boxes_kept + 1'b1;
      if (boxes_kept > cfg_box_limit) frame_closed = 1'b1;
      return 1'b1;
   endfunction

   function automatic void check_field(input string field, input logic [VALUE_BITS-1:0] want,
                                       input logic [VALUE_BITS-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", field, $signed(want), $signed(got));
         mismatches++;
      end
   endfunction

   function automatic void compare_box(input rsp_type want, input rsp_type got);
      check_field("left", want.left, got.left);
      check_field("top", want.top, got.top);
      check_field("right", want.right, got.right);
      check_field("bottom", want.bottom, got.bottom);
      check_field("center_x", want.center_x, got.center_x);
      check_field("center_y", want.center_y, got.center_y);
      check_field("box_width", want.box_width, got.box_width);
      check_field("box_height", want.box_height, got.box_height);
      check_field("rotation", want.rotation, got.rotation);
      check_field("confidence", want.confidence, got.confidence);
      check_field("class_index", VALUE_BITS'(want.class_index), VALUE_BITS'(got.class_index));
   endfunction

   // Predicts on every accepted item, checks every accepted box and tracks register writes.
   always @(posedge clock) begin
      rsp_type box;
      if (reset) begin
         reset_model();
      end else begin
         if (req_valid && req_ready) begin
            if (predict_box(req_data.value, req_data.first_of_frame, box))
               expected_boxes.insert(expected_boxes.size(), box);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_boxes.size() == 0) begin
               $error("box received while none was expected");
               mismatches++;
            end else begin
               compare_box(expected_boxes.pop_front(), rsp_data);
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_NUM_CLASSES:     cfg_num_classes  = csr_data[NC_BITS-1:0];
               CSR_SCORE_THRESHOLD: cfg_threshold    = csr_data[VALUE_BITS-1:0];
               CSR_X_FACTOR:        cfg_x_factor     = csr_data[FACTOR_BITS-1:0];
               CSR_Y_FACTOR:        cfg_y_factor     = csr_data[FACTOR_BITS-1:0];
               CSR_IMAGE_WIDTH:     cfg_image_width  = csr_data[SIZE_BITS-1:0];
               CSR_IMAGE_HEIGHT:    cfg_image_height = csr_data[SIZE_BITS-1:0];
               CSR_BOX_LIMIT:       cfg_box_limit    = csr_data[LIMIT_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // Result side back-pressure: random stalls while idling is on.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog on cycles in which nothing moves on any port.
   always @(posedge clock) begin
      if (reset || csr_write || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sends one channel value and returns at the edge where it is accepted.
   // Valid stays high afterwards, so the caller sends again or drops it in the same step.
   task automatic send_value(input logic [VALUE_BITS-1:0] chan_value, input logic first);
      int gap;
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{value: chan_value, first_of_frame: first};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
   endtask

   // Stops sending and waits until every expected box has arrived.
   task automatic hold_until_empty();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_boxes.size() != 0) @(posedge clock);
   endtask

   // As above, plus time for the pipeline to settle before registers change.
   task automatic wait_idle();
      hold_until_empty();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [NC_BITS-1:0] classes,
                                input logic [VALUE_BITS-1:0] threshold,
                                input logic [FACTOR_BITS-1:0] x_scale, y_scale,
                                input logic [SIZE_BITS-1:0] width, height,
                                input logic [LIMIT_BITS-1:0] limit);
      write_reg(CSR_NUM_CLASSES, CSR_DATA_BITS'(classes));
      write_reg(CSR_SCORE_THRESHOLD, CSR_DATA_BITS'(threshold));
      write_reg(CSR_X_FACTOR, CSR_DATA_BITS'(x_scale));
      write_reg(CSR_Y_FACTOR, CSR_DATA_BITS'(y_scale));
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(width));
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(height));
      write_reg(CSR_BOX_LIMIT, CSR_DATA_BITS'(limit));
      csr_write     <= 1'b0;
      gen_classes   = (classes == 0) ? 1 : int'(classes);
      gen_threshold = threshold;
   endtask

   task automatic load_random_settings();
      load_settings(NC_BITS'($urandom_range(0, 8)),
                    VALUE_BITS'($urandom_range(0, 32'h40000)) - 32'h20000,
                    FACTOR_BITS'($urandom_range(0, 24'h40000)),
                    FACTOR_BITS'($urandom_range(0, 24'h40000)),
                    SIZE_BITS'($urandom_range(1, 8192)),
                    SIZE_BITS'($urandom_range(1, 8192)),
                    LIMIT_BITS'($urandom_range(0, 12)));
   endtask

   function automatic logic [VALUE_BITS-1:0] pixels(input int n);
      return VALUE_BITS'(n <<< FRAC_BITS);
   endfunction

   // Box value: mostly plausible pixel positions with a fraction, sometimes extremes.
   function automatic logic [VALUE_BITS-1:0] pick_coord(input int max_px);
      case ($urandom_range(0, 11))
         0:       return $urandom;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return '0;
         4:       return -($urandom_range(1, 50) << FRAC_BITS);
         default: return ($urandom_range(0, max_px) << FRAC_BITS) | ($urandom & 32'hFFFF);
      endcase
   endfunction

   // Class score: near the threshold, from a small set that produces ties, or extremes.
   function automatic logic [VALUE_BITS-1:0] pick_score();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return gen_threshold;
         4, 5:    return $urandom_range(0, 3) << 14;
         default: return gen_threshold + $urandom_range(0, 65536) - 32768;
      endcase
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_angle();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // One anchor with random content; a cut position truncates it, and now and then
   // a frame start lands in the middle.
   task automatic send_anchor(input bit start_frame, input int cut);
      int                    len;
      logic [VALUE_BITS-1:0] v;
      logic                  first;
      len = BOX_CHANNELS + gen_classes + 1;
      for (int p = 0; p < len && p != cut; p++) begin
         if (p < 2) v = pick_coord(700);
         else if (p < BOX_CHANNELS) v = pick_coord(300);
         else if (p < len - 1) v = pick_score();
         else v = pick_angle();
         first = (p == 0 && start_frame) || ($urandom_range(0, 59) == 0);
         send_value(v, first);
      end
   endtask

   task automatic stream_anchors(input int count);
      int stop_at;
      int cut;
      stop_at = sent_items + count;
      while (sent_items < stop_at) begin
         cut = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, gen_classes + 4)) : -1;
         send_anchor($urandom_range(0, 5) == 0, cut);
      end
   endtask

   // A single-class anchor with fixed content.
   task automatic send_fixed_anchor(input logic [VALUE_BITS-1:0] cx, cy, w, h, score, angle,
                                    input logic first);
      send_value(cx, first);
      send_value(cy, 1'b0);
      send_value(w, 1'b0);
      send_value(h, 1'b0);
      send_value(score, 1'b0);
      send_value(angle, 1'b0);
   endtask

   // Threshold equality, frame closing at the box limit, saturation, a score below the
   // threshold, and a frame restart in the middle of an anchor.
   task automatic test_directed_anchors();
      load_settings(8'd1, 32'd0, 24'd65536, 24'd65536, 14'd640, 14'd640, 16'd0);
      send_fixed_anchor(pixels(100), pixels(50), pixels(40), pixels(20), 32'd0, 32'h4000, 1'b1);
      send_fixed_anchor(pixels(600), pixels(600), pixels(100), pixels(100), 32'h7FFF_FFFF,
                        32'h1000, 1'b0);
      send_fixed_anchor(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_fixed_anchor(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      send_value(pixels(5), 1'b0);
      send_value(pixels(6), 1'b0);
      send_fixed_anchor(pixels(630), pixels(630), pixels(30), pixels(30), 32'd1,
                        32'hFFFF_0000, 1'b1);
      wait_idle();
   endtask

   // The class count drops in the middle of an anchor, so the next value is the angle.
   task automatic test_class_count_change();
      load_settings(8'd4, 32'h8000_0000, 24'h018000, 24'h018000, 14'd8192, 14'd8192,
                    16'd65535);
      send_value(pixels(200), 1'b1);
      send_value(pixels(150), 1'b0);
      send_value(pixels(60), 1'b0);
      send_value(pixels(80), 1'b0);
      send_value(32'h8000, 1'b0);
      send_value(32'h18000, 1'b0);
      send_value(32'h18000, 1'b0);
      wait_idle();
      write_reg(CSR_NUM_CLASSES, CSR_DATA_BITS'(1));
      csr_write   <= 1'b0;
      gen_classes = 1;
      send_value(32'h1234_5678, 1'b0);
      send_fixed_anchor(pixels(10), pixels(20), pixels(30), pixels(40), 32'd7, 32'd0, 1'b0);
      wait_idle();
   endtask

   // Zero classes act as one; lowest threshold keeps every box.
   task automatic test_zero_classes_open();
      load_settings(8'd0, 32'h8000_0000, 24'd65536, 24'd65536, 14'd640, 14'd480, 16'd65535);
      stream_anchors(150);
      wait_idle();
   endtask

   // Largest and zero factors, a zero-pixel image width, widest height, one box per frame.
   task automatic test_extreme_scaling();
      load_settings(8'd3, 32'd0, 24'hFF_FFFF, 24'd0, 14'd0, 14'h3FFF, 16'd0);
      stream_anchors(150);
      wait_idle();
   endtask

   task automatic test_full_class_count();
      load_settings(8'd255, 32'hFFFF_8000, 24'h00C000, 24'h014000, 14'd1280, 14'd720, 16'd2);
      stream_anchors(250);
      wait_idle();
   endtask

   // Highest threshold: only a score at the top of the range gets through.
   task automatic test_strict_threshold();
      load_settings(8'd2, 32'h7FFF_FFFF, 24'd1, 24'h80_0000, 14'd1920, 14'd1080, 16'd1);
      stream_anchors(100);
      wait_idle();
   endtask

   // Random settings, with the sender holding off once until every box is out.
   task automatic test_random_settings();
      load_random_settings();
      stream_anchors(120);
      hold_until_empty();
      stream_anchors(130);
      wait_idle();
   endtask

   // Closing stretch at full rate on both sides.
   task automatic test_back_to_back();
      tx_idle_on = 1'b0;
      rx_idle_on <= 1'b0;
      load_random_settings();
      stream_anchors(300);
      wait_idle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_anchors();
      test_class_count_change();
      test_zero_classes_open();
      test_extreme_scaling();
      test_full_class_count();
      test_strict_threshold();
      test_random_settings();
      test_back_to_back();
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/aocad_pkg.sv
hw/rtl/anchor_obb_class_argmax_decode_top.sv
bench/tb_anchor_obb_class_argmax_decode_top.sv
